/* hdl/tzs_pkg.sv */
`default_nettype none

package tzs_pkg;

  // Number of zoom levels; the travel table below has 32 slots.
  localparam int LEVELS_DEFAULT = 30;
  localparam int LEVEL_W = 5;
  localparam int TICKS_W = 9;
  localparam int ADDR_W = 8;

  // Depth of the job queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Pelco-D frame geometry.
  localparam int FRAME_BEATS = 7;
  localparam int BEAT_W = 3;
  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BEATS - 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ZOOM_IN_BYTE = 8'h20;
  localparam logic [7:0] ZOOM_OUT_BYTE = 8'h40;
  localparam logic [7:0] STOP_BYTE = 8'h00;
  localparam logic [7:0] MOVE_DATA = 8'h01;
  localparam logic [7:0] STOP_DATA = 8'h00;

  // Input actions.
  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_HOME = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAME = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_CAMERA_ADDRESS = 1'b0;
  localparam logic [0:0] REG_SETTLE_TICKS = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MOVE,
    PH_SETTLE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_ZOOM_IN,
    CMD_ZOOM_OUT,
    CMD_STOP
  } cmd_t;

  // One unit of work for the back end: a seven-beat frame or one status beat.
  typedef struct packed {
    logic                is_frame;
    logic [1:0]          status;
    cmd_t                cmd;
    logic [LEVEL_W-1:0]  level;
  } job_t;

  // Lens travel time from minimum zoom to each level, in 10 ms ticks.
  function automatic logic [TICKS_W-1:0] travel_ticks(input logic [LEVEL_W-1:0] idx);
    logic [TICKS_W-1:0] t;
    case (idx)
      5'd0:    t = 9'd0;
      5'd1:    t = 9'd100;
      5'd2:    t = 9'd150;
      5'd3:    t = 9'd170;
      5'd4:    t = 9'd190;
      5'd5:    t = 9'd205;
      5'd6:    t = 9'd215;
      5'd7:    t = 9'd226;
      5'd8:    t = 9'd236;
      5'd9:    t = 9'd240;
      5'd10:   t = 9'd251;
      5'd11:   t = 9'd257;
      5'd12:   t = 9'd264;
      5'd13:   t = 9'd270;
      5'd14:   t = 9'd277;
      5'd15:   t = 9'd289;
      5'd16:   t = 9'd298;
      5'd17:   t = 9'd314;
      5'd18:   t = 9'd325;
      5'd19:   t = 9'd340;
      5'd20:   t = 9'd354;
      5'd21:   t = 9'd365;
      5'd22:   t = 9'd377;
      5'd23:   t = 9'd390;
      5'd24:   t = 9'd402;
      5'd25:   t = 9'd415;
      5'd26:   t = 9'd427;
      5'd27:   t = 9'd440;
      5'd28:   t = 9'd450;
      default: t = 9'd460;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t cmd);
    logic [7:0] b;
    case (cmd)
      CMD_ZOOM_IN:  b = ZOOM_IN_BYTE;
      CMD_ZOOM_OUT: b = ZOOM_OUT_BYTE;
      default:      b = STOP_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hdl/timed_zoom_sequencer.sv */
// Timed zoom sequencer: open-loop zoom control of a Pelco-D camera lens.
// Input beats on s_* carry an action (request a level, one 10 ms tick, or
// home) in s_tuser and the target level in s_tdata. Output beats on m_*
// carry either one byte of a 7-byte Pelco-D frame or one status-only beat.
// A request or home that starts a move yields 7 beats; a tick that ends a
// move yields the 7-beat stop frame; a rejected request or home yields one
// status beat; other ticks and action 3 yield nothing. m_tlast marks the
// final beat of each run. The front end decides each item in the cycle it
// is accepted and can take one item per cycle while the 4-entry job queue
// has room. Each job passes a queue entry, the back end's current-job
// register and the output register, which emits one beat per cycle while
// m_tready is high; that single output register sets the sustained rate.
// When the receiver holds m_tready low, the current beat stays registered,
// the queue fills, and s_tready drops only once the queue is full.
// Reset (rst, synchronous) returns the level to 0, the block to idle, the
// camera address to 2 and the settle time to 5 ticks, and empties the queue.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are meant for idle
// periods only.
`default_nettype none

module timed_zoom_sequencer #(
  parameter int LEVELS = tzs_pkg::LEVELS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [5:0] target, [7:6] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] status,
                                      // [14:10] current_level, [15] zero
  output logic [0:0]       m_tuser,   // [0] frame_valid
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] camera_address;
  logic [7:0] settle_ticks;

  logic q_push, q_pop, q_full, q_empty;
  tzs_pkg::job_t push_job, head_job;

  logic [7:0] out_byte;
  logic frame_valid;
  logic [1:0] status;
  logic [tzs_pkg::LEVEL_W-1:0] current_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_address <= 8'd2;
      settle_ticks <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        tzs_pkg::REG_CAMERA_ADDRESS: camera_address <= cfg_wdata;
        tzs_pkg::REG_SETTLE_TICKS:   settle_ticks <= cfg_wdata;
        default:                     camera_address <= camera_address;
      endcase
    end
  end

  // Front end: classifies each item and keeps the zoom state.
  tzs_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .action       (s_tuser),
    .target       (s_tdata[5:0]),
    .settle_ticks (settle_ticks),
    .full         (q_full),
    .push         (q_push),
    .push_job     (push_job)
  );

  tzs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: serializes frames and status results into output beats.
  tzs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (q_empty),
    .head_job       (head_job),
    .pop            (q_pop),
    .camera_address (camera_address),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (out_byte),
    .frame_valid    (frame_valid),
    .last           (m_tlast),
    .status         (status),
    .current_level  (current_level)
  );

  assign m_tdata = {1'b0, current_level, status, out_byte};
  assign m_tuser = frame_valid;

  // The front end never writes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job queue overflow");

  // The back end never takes a job from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job queue underflow");

  // A rejection is always a single status-only beat.
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[9:8] != tzs_pkg::ST_OK)) |-> (m_tlast && !m_tuser[0]))
    else $error("status result not a single status-only beat");

endmodule

`default_nettype wire

/* hdl/tzs_front.sv */
`default_nettype none

// Takes one item per cycle while the queue has room, checks it against the
// zoom state, updates it at once and queues any result as a back-end job.
module tzs_front #(
  parameter int LEVELS = tzs_pkg::LEVELS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   action,
  input  wire logic [5:0]                   target,
  input  wire logic [7:0]                   settle_ticks,
  input  wire logic                         full,
  output logic                              push,
  output tzs_pkg::job_t                     push_job
);

  localparam logic [6:0] LevelsW = 7'(LEVELS);
  localparam logic [tzs_pkg::LEVEL_W-1:0] HomeIdx = tzs_pkg::LEVEL_W'(LEVELS - 1);

  tzs_pkg::phase_t phase, phase_next;
  logic [tzs_pkg::LEVEL_W-1:0] level, level_next;
  logic [tzs_pkg::LEVEL_W-1:0] pending_level, pending_level_next;
  logic [tzs_pkg::TICKS_W-1:0] countdown, countdown_next;

  logic accept;
  logic busy;
  logic bad_target;
  logic same_target;
  logic [tzs_pkg::TICKS_W-1:0] from_t, to_t, diff, cd_dec;
  logic cd_done;
  logic settle_zero;

  assign in_ready = !full;
  assign accept = in_valid && in_ready;
  assign busy = (phase == tzs_pkg::PH_MOVE) || (phase == tzs_pkg::PH_SETTLE);
  assign bad_target = ({1'b0, target} >= LevelsW);
  assign same_target = (target[tzs_pkg::LEVEL_W-1:0] == level);
  assign from_t = tzs_pkg::travel_ticks(level);
  assign to_t = tzs_pkg::travel_ticks(target[tzs_pkg::LEVEL_W-1:0]);
  assign diff = (to_t > from_t) ? (to_t - from_t) : (from_t - to_t);
  assign cd_dec = (countdown != '0) ? (countdown - tzs_pkg::TICKS_W'(1)) : '0;
  assign cd_done = (cd_dec == '0);
  assign settle_zero = (settle_ticks == '0);

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (action)
        tzs_pkg::ACT_REQUEST: begin
          if (!bad_target && !busy && !same_target) begin
            phase_next = tzs_pkg::PH_MOVE;
          end
        end
        tzs_pkg::ACT_HOME: begin
          if (!busy) begin
            phase_next = tzs_pkg::PH_MOVE;
          end
        end
        tzs_pkg::ACT_TICK: begin
          if (phase == tzs_pkg::PH_MOVE && cd_done) begin
            phase_next = settle_zero ? tzs_pkg::PH_IDLE : tzs_pkg::PH_SETTLE;
          end else if (phase == tzs_pkg::PH_SETTLE && cd_done) begin
            phase_next = tzs_pkg::PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Data state and job output.
  always_comb begin
    level_next = level;
    pending_level_next = pending_level;
    countdown_next = countdown;
    push = 1'b0;
    push_job.is_frame = 1'b0;
    push_job.status = tzs_pkg::ST_OK;
    push_job.cmd = tzs_pkg::CMD_STOP;
    push_job.level = level;
    if (accept) begin
      case (action)
        tzs_pkg::ACT_REQUEST: begin
          push = 1'b1;
          if (bad_target) begin
            push_job.status = tzs_pkg::ST_INVALID;
          end else if (busy) begin
            push_job.status = tzs_pkg::ST_BUSY;
          end else if (same_target) begin
            push_job.status = tzs_pkg::ST_SAME;
          end else begin
            push_job.is_frame = 1'b1;
            push_job.cmd = (target[tzs_pkg::LEVEL_W-1:0] > level) ?
                           tzs_pkg::CMD_ZOOM_IN : tzs_pkg::CMD_ZOOM_OUT;
            countdown_next = diff;
            pending_level_next = target[tzs_pkg::LEVEL_W-1:0];
          end
        end
        tzs_pkg::ACT_HOME: begin
          push = 1'b1;
          if (busy) begin
            push_job.status = tzs_pkg::ST_BUSY;
          end else begin
            push_job.is_frame = 1'b1;
            push_job.cmd = tzs_pkg::CMD_ZOOM_OUT;
            countdown_next = tzs_pkg::travel_ticks(HomeIdx);
            pending_level_next = '0;
          end
        end
        tzs_pkg::ACT_TICK: begin
          if (phase == tzs_pkg::PH_MOVE) begin
            if (cd_done) begin
              // Stop frame already reports the level reached.
              push = 1'b1;
              push_job.is_frame = 1'b1;
              push_job.level = pending_level;
              level_next = pending_level;
              countdown_next = {1'b0, settle_ticks};
            end else begin
              countdown_next = cd_dec;
            end
          end else if (phase == tzs_pkg::PH_SETTLE) begin
            countdown_next = cd_dec;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tzs_pkg::PH_IDLE;
      level <= '0;
      pending_level <= '0;
      countdown <= '0;
    end else begin
      phase <= phase_next;
      level <= level_next;
      pending_level <= pending_level_next;
      countdown <= countdown_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/tzs_queue.sv */
`default_nettype none

// Small first-in first-out buffer of jobs between front and back end.
module tzs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tzs_pkg::job_t push_job,
  input  wire logic          pop,
  output tzs_pkg::job_t      head_job,
  output logic               full,
  output logic               empty
);

  localparam int PtrW = $clog2(tzs_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(tzs_pkg::QUEUE_DEPTH + 1);

  tzs_pkg::job_t entries [tzs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(tzs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/tzs_back.sv */
`default_nettype none

// Turns jobs into beats: seven Pelco-D frame bytes or one status beat,
// through an output register that holds a beat while the receiver stalls.
module tzs_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          empty,
  input  wire tzs_pkg::job_t                 head_job,
  output logic                               pop,
  input  wire logic [7:0]                    camera_address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               frame_valid,
  output logic                               last,
  output logic [1:0]                         status,
  output logic [tzs_pkg::LEVEL_W-1:0]        current_level
);

  logic cur_valid;
  tzs_pkg::job_t cur_job;
  logic [tzs_pkg::BEAT_W-1:0] beat_idx;

  logic load;
  logic last_beat;
  logic [7:0] cmd_b, data_b, sum_b, beat_byte;

  assign last_beat = !cur_job.is_frame || (beat_idx == tzs_pkg::LAST_BEAT);
  assign load = cur_valid && (!out_valid || out_ready);
  assign pop = !empty && (!cur_valid || (load && last_beat));

  assign cmd_b = tzs_pkg::cmd_byte(cur_job.cmd);
  assign data_b = (cur_job.cmd == tzs_pkg::CMD_STOP) ? tzs_pkg::STOP_DATA :
                  tzs_pkg::MOVE_DATA;
  assign sum_b = camera_address + cmd_b + data_b;

  always_comb begin
    case (beat_idx)
      3'd0:    beat_byte = tzs_pkg::SYNC_BYTE;
      3'd1:    beat_byte = camera_address;
      3'd3:    beat_byte = cmd_b;
      3'd4:    beat_byte = data_b;
      3'd6:    beat_byte = sum_b;
      default: beat_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        beat_idx <= '0;
      end else if (load) begin
        if (last_beat) begin
          cur_valid <= 1'b0;
        end else begin
          beat_idx <= beat_idx + tzs_pkg::BEAT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_job <= head_job;
    end
    if (load) begin
      out_byte <= cur_job.is_frame ? beat_byte : 8'h00;
      frame_valid <= cur_job.is_frame;
      last <= last_beat;
      status <= cur_job.status;
      current_level <= cur_job.level;
    end
  end

endmodule

`default_nettype wire

/* sim/timed_zoom_sequencer_tb.sv */
`timescale 1ns / 100ps

module timed_zoom_sequencer_tb;

  // Action code 3 is not defined; the block must drop such beats silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int GAP_MAX = 8;          // longest idle gap on either side
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off for back-pressure
  localparam int STALL_LIMIT = 2000;   // cycles without any accepted beat
  localparam int DRAIN_CYCLES = 12;    // latency margin once nothing is expected
  localparam int BURST_ITEMS = 10;     // rejected beats offered during the hold-off
  localparam int STREAM_ITEMS = 6;     // rejected beats sent back to back
  localparam int PRINT_CAP = 40;

  // One output beat as the lens controller should produce it.
  typedef struct {
    logic [7:0]                  data_byte;
    logic                        frame_valid;
    logic                        last;
    logic [1:0]                  status;
    logic [tzs_pkg::LEVEL_W-1:0] level;
  } zoom_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;

  // Lens travel time from minimum zoom to each level, in 10 ms ticks. Slots
  // past the measured levels repeat the longest time.
  int lens_travel [32] = '{
    0, 100, 150, 170, 190, 205, 215, 226, 236, 240,
    251, 257, 264, 270, 277, 289, 298, 314, 325, 340,
    354, 365, 377, 390, 402, 415, 427, 440, 450, 460,
    460, 460
  };

  // Shadow copy of the controller state and its two registers, at reset values.
  logic [tzs_pkg::LEVEL_W-1:0] zoom_level = '0;
  logic [tzs_pkg::LEVEL_W-1:0] pending_level = '0;
  tzs_pkg::phase_t             zoom_phase = tzs_pkg::PH_IDLE;
  int                          ticks_left = 0;
  logic [7:0]                  cam_addr = 8'd2;
  logic [7:0]                  settle_len = 8'd5;

  zoom_beat_t expected_beats [$];

  int  mismatch_count = 0;
  bit  tx_burst = 1'b0;   // sender offers beats back to back
  bit  rx_burst = 1'b0;   // receiver never stalls
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off

  always #5 clk = ~clk;

  timed_zoom_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
  endtask

  // Queue the seven bytes of a Pelco-D frame. The checksum is the 8-bit sum
  // of the address, command and data bytes (the two zero bytes add nothing).
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] data1);
    logic [7:0] frame [tzs_pkg::FRAME_BEATS];
    zoom_beat_t b;
    frame[0] = tzs_pkg::SYNC_BYTE;
    frame[1] = cam_addr;
    frame[2] = 8'h00;
    frame[3] = cmd;
    frame[4] = data1;
    frame[5] = 8'h00;
    frame[6] = cam_addr + cmd + data1;
    for (int i = 0; i < tzs_pkg::FRAME_BEATS; i++) begin
      b.data_byte = frame[i];
      b.frame_valid = 1'b1;
      b.last = (i == tzs_pkg::FRAME_BEATS - 1);
      b.status = tzs_pkg::ST_OK;
      b.level = zoom_level;
      expected_beats.push_back(b);
    end
  endtask

  task automatic queue_status(input logic [1:0] code);
    zoom_beat_t b;
    b.data_byte = 8'h00;
    b.frame_valid = 1'b0;
    b.last = 1'b1;
    b.status = code;
    b.level = zoom_level;
    expected_beats.push_back(b);
  endtask

  // Advance the shadow controller by one accepted input beat and queue what
  // it should emit. A rejected request is checked for an invalid target
  // first, then for a move or settle in progress, then for the same level.
  task automatic predict_zoom(input logic [1:0] act, input logic [5:0] tgt);
    int from_t;
    int to_t;
    case (act)
      tzs_pkg::ACT_REQUEST: begin
        if (tgt >= tzs_pkg::LEVELS_DEFAULT) begin
          queue_status(tzs_pkg::ST_INVALID);
        end else if (zoom_phase != tzs_pkg::PH_IDLE) begin
          queue_status(tzs_pkg::ST_BUSY);
        end else if (tgt[tzs_pkg::LEVEL_W-1:0] == zoom_level) begin
          queue_status(tzs_pkg::ST_SAME);
        end else begin
          from_t = lens_travel[zoom_level];
          to_t = lens_travel[tgt[tzs_pkg::LEVEL_W-1:0]];
          ticks_left = (to_t > from_t) ? to_t - from_t : from_t - to_t;
          pending_level = tgt[tzs_pkg::LEVEL_W-1:0];
          zoom_phase = tzs_pkg::PH_MOVE;
          queue_frame((tgt[tzs_pkg::LEVEL_W-1:0] > zoom_level) ?
                      tzs_pkg::ZOOM_IN_BYTE : tzs_pkg::ZOOM_OUT_BYTE,
                      tzs_pkg::MOVE_DATA);
        end
      end
      tzs_pkg::ACT_HOME: begin
        if (zoom_phase != tzs_pkg::PH_IDLE) begin
          queue_status(tzs_pkg::ST_BUSY);
        end else begin
          ticks_left = lens_travel[tzs_pkg::LEVELS_DEFAULT - 1];
          pending_level = '0;
          zoom_phase = tzs_pkg::PH_MOVE;
          queue_frame(tzs_pkg::ZOOM_OUT_BYTE, tzs_pkg::MOVE_DATA);
        end
      end
      tzs_pkg::ACT_TICK: begin
        if (zoom_phase == tzs_pkg::PH_MOVE) begin
          if (ticks_left > 0) ticks_left--;
          if (ticks_left == 0) begin
            // The stop frame already carries the new level.
            zoom_level = pending_level;
            ticks_left = settle_len;
            if (settle_len == 0) zoom_phase = tzs_pkg::PH_IDLE;
            else zoom_phase = tzs_pkg::PH_SETTLE;
            queue_frame(tzs_pkg::STOP_BYTE, tzs_pkg::STOP_DATA);
          end
        end else if (zoom_phase == tzs_pkg::PH_SETTLE) begin
          if (ticks_left > 0) ticks_left--;
          if (ticks_left == 0) zoom_phase = tzs_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one input beat after a random gap and predict it once accepted.
  // tvalid stays high on return so that a following beat can go out back to
  // back; anything that pauses the stream lowers it first.
  task automatic send_item(input logic [1:0] act, input logic [5:0] tgt);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {2'b00, tgt};
    do @(posedge clk); while (!s_tready);
    predict_zoom(act, tgt);
  endtask

  // A request or home that the block must turn away while it is busy.
  task automatic send_rejected;
    case ($urandom_range(0, 2))
      0:       send_item(tzs_pkg::ACT_HOME, 6'($urandom_range(0, 63)));
      1:       send_item(tzs_pkg::ACT_REQUEST, 6'($urandom_range(30, 63)));
      default: send_item(tzs_pkg::ACT_REQUEST, 6'($urandom_range(0, 29)));
    endcase
  endtask

  // Feed ticks until the move ends, and through the settle time as well when
  // asked. The target field of a tick carries random bits.
  task automatic run_ticks(input bit through_settle);
    while (zoom_phase == tzs_pkg::PH_MOVE ||
           (through_settle && zoom_phase == tzs_pkg::PH_SETTLE)) begin
      send_item(tzs_pkg::ACT_TICK, 6'($urandom_range(0, 63)));
    end
  endtask

  // Stop offering beats and wait until every expected beat has come out,
  // plus a margin for anything still in flight.
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges; only call when idle.
  task automatic set_config(input logic [7:0] addr, input logic [7:0] settle);
    cfg_we <= 1'b1;
    cfg_index <= tzs_pkg::REG_CAMERA_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cam_addr = addr;
    cfg_index <= tzs_pkg::REG_SETTLE_TICKS;
    cfg_wdata <= settle;
    @(posedge clk);
    settle_len = settle;
    cfg_we <= 1'b0;
  endtask

  // Reset values at level 0: the same level, invalid levels, the unused
  // action and a quiet tick, none of which moves the lens.
  task automatic test_status_at_rest;
    send_item(tzs_pkg::ACT_REQUEST, 6'd0);    // already there
    send_item(tzs_pkg::ACT_REQUEST, 6'd30);   // first invalid level
    send_item(tzs_pkg::ACT_REQUEST, 6'd63);
    send_item(ACT_UNUSED, 6'd5);              // dropped without a result
    send_item(tzs_pkg::ACT_TICK, 6'd0);       // quiet tick while idle
    wait_idle;
  endtask

  // Zoom in by one level with the reset address and settle time, with
  // rejections while moving and while settling.
  task automatic test_zoom_in;
    send_item(tzs_pkg::ACT_REQUEST, 6'd1);
    send_item(tzs_pkg::ACT_HOME, 6'd63);      // home while moving is busy
    send_item(tzs_pkg::ACT_REQUEST, 6'd40);   // invalid wins over busy
    send_item(tzs_pkg::ACT_REQUEST, 6'd0);    // busy while moving
    run_ticks(1'b0);
    send_item(tzs_pkg::ACT_REQUEST, 6'd8);    // busy while settling
    run_ticks(1'b1);
    wait_idle;
  endtask

  // Register extremes: address 0xFF makes the checksum wrap, and with no
  // settle time the block is idle right after the stop frame.
  task automatic test_config_extremes;
    set_config(8'hFF, 8'd0);
    send_item(tzs_pkg::ACT_REQUEST, 6'd0);    // zoom out to the minimum
    run_ticks(1'b1);
  endtask

  // Home is taken right after the stop frame and moves even from level 0.
  task automatic test_home;
    send_item(tzs_pkg::ACT_HOME, 6'd17);
    wait_idle;
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the job queue fills and the block stops taking input.
  task automatic test_output_backpressure;
    tx_burst = 1'b1;
    hold_req = 1'b1;
    repeat (BURST_ITEMS) send_rejected();
    wait_idle;
    tx_burst = 1'b0;
  endtask

  // No idling on either side: rejected beats go out back to back.
  task automatic test_back_to_back;
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (STREAM_ITEMS) send_rejected();
    wait_idle;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Compare one accepted output beat against the oldest expectation.
  task automatic check_beat;
    zoom_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected", m_tdata, 16'h0000);
      return;
    end
    want = expected_beats.pop_front();
    if (m_tdata[7:0] !== want.data_byte) report_mismatch("out_byte", m_tdata[7:0], want.data_byte);
    if (m_tdata[9:8] !== want.status) report_mismatch("status", m_tdata[9:8], want.status);
    if (m_tdata[14:10] !== want.level) report_mismatch("current_level", m_tdata[14:10], want.level);
    if (m_tuser[0] !== want.frame_valid) report_mismatch("frame_valid", m_tuser[0], want.frame_valid);
    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
  endtask

  // Receiver: a random stall before each beat, none in burst mode, and one
  // long hold-off when asked for, counted here in cycles.
  initial begin : receiver
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_beat();
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** timed_zoom_sequencer: FAILED **");
    $finish;
  end

  // Reset once, then run the tests in turn and give the verdict.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_status_at_rest();
    test_zoom_in();
    test_config_extremes();
    test_home();
    test_output_backpressure();
    test_back_to_back();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("** timed_zoom_sequencer: PASSED **");
    end else begin
      $display("** timed_zoom_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tzs_pkg.sv
hdl/tzs_front.sv
hdl/tzs_queue.sv
hdl/tzs_back.sv
hdl/timed_zoom_sequencer.sv
sim/timed_zoom_sequencer_tb.sv
